### rtl/deq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int FUNC_W = 3;
  localparam int STAT_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_NONE       = 3'd0,
    FUNC_PUSH_FRONT = 3'd1,
    FUNC_PUSH_REAR  = 3'd2,
    FUNC_POP_FRONT  = 3'd3,
    FUNC_POP_REAR   = 3'd4
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Operation broadcast to every cell; already gated by full/empty and accept.
  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic pop_rear;
  } cell_cmd_t;

endpackage

`default_nettype wire

### rtl/deq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module deq_cell
  import deq_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cell_cmd_t                cmd,
  input  wire logic signed [DATA_W-1:0] push_word,
  input  wire logic signed [DATA_W-1:0] left_data,
  input  wire logic                     left_valid,
  input  wire logic signed [DATA_W-1:0] right_data,
  input  wire logic                     right_valid,
  input  wire logic                     right_last,
  output logic signed [DATA_W-1:0]      data,
  output logic                          valid,
  output logic                          last,
  output logic signed [DATA_W-1:0]      rear_word,
  output logic signed [DATA_W-1:0]      prev_rear_word
);

  logic                     prev_last;
  logic                     rear_slot;
  logic signed [DATA_W-1:0] data_next;
  logic                     valid_next;

  assign last           = valid & ~right_valid;
  assign prev_last      = valid & right_last;
  assign rear_slot      = ~valid & left_valid;
  assign rear_word      = last ? data : '0;
  assign prev_rear_word = prev_last ? data : '0;

  always_comb begin
    data_next  = data;
    valid_next = valid;
    priority if (cmd.push_front) begin
      // Shift toward the rear.
      data_next  = left_data;
      valid_next = left_valid;
    end else if (cmd.pop_front) begin
      // Shift toward the front.
      data_next  = right_data;
      valid_next = right_valid;
    end else if (cmd.push_rear && rear_slot) begin
      data_next  = push_word;
      valid_next = 1'b1;
    end else if (cmd.pop_rear && last) begin
      valid_next = 1'b0;
    end else begin
      // Hold.
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

`default_nettype wire

### rtl/double_ended_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Double-ended queue of signed 32-bit words, DEPTH entries deep.
// Input channel (in_valid/in_ready) carries one word per operation: func picks
// none, push front, push rear, pop front or pop rear; value is the word to push.
// Output channel (out_valid/out_ready) returns one word per operation: the
// popped word, the words now at front and rear, the occupancy, an empty flag
// and a status (ok, push dropped because full, pop refused because empty).
// Storage is a row of cells: cell 0 holds the front, each further valid cell
// the next word. Front pushes and pops shift the whole row one place; rear
// pushes and pops touch only the cell at the boundary of the valid run, so
// every operation completes in the cycle it is accepted.
// The result is registered and shows on the output in the cycle after
// acceptance. Throughput: one operation per cycle while out_ready is high,
// set by the single output register; in_ready is high whenever that register
// is empty or being taken. When the receiver stalls, the result holds in the
// output register and in_ready drops until it is taken; no operation is lost
// or repeated. Reset (rst, synchronous, active high) empties the queue and the
// output register; stored word values are not cleared and need not be.

module double_ended_queue_unit
  import deq_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [FUNC_W-1:0]        func,
  input  wire logic signed [DATA_W-1:0] value,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [DATA_W-1:0]      popped_value,
  output logic signed [DATA_W-1:0]      front_value,
  output logic signed [DATA_W-1:0]      rear_value,
  output logic [CNT_W-1:0]              occupancy,
  output logic                          is_empty,
  output logic [STAT_W-1:0]             status
);

  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic                     full;
  logic                     empty;
  logic                     accept;
  cell_cmd_t                cmd;
  cell_cmd_t                cell_cmd;
  status_t                  stat;

  logic signed [DATA_W-1:0] cell_data      [DEPTH];
  logic                     cell_valid     [DEPTH];
  logic                     cell_last      [DEPTH];
  logic signed [DATA_W-1:0] cell_rear      [DEPTH];
  logic signed [DATA_W-1:0] cell_prev_rear [DEPTH];

  logic signed [DATA_W-1:0] rear_now;
  logic signed [DATA_W-1:0] rear_prev;
  logic signed [DATA_W-1:0] res_popped;
  logic signed [DATA_W-1:0] res_front;
  logic signed [DATA_W-1:0] res_rear;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign in_ready = ~out_valid | out_ready;
  assign accept   = in_valid & in_ready;
  assign cell_cmd = accept ? cmd : '0;

  // Decode the operation; refuse pushes when full and pops when empty.
  always_comb begin
    cmd  = '0;
    stat = ST_OK;
    unique case (func)
      FUNC_PUSH_FRONT: begin
        if (full) stat = ST_FULL;
        else cmd.push_front = 1'b1;
      end
      FUNC_PUSH_REAR: begin
        if (full) stat = ST_FULL;
        else cmd.push_rear = 1'b1;
      end
      FUNC_POP_FRONT: begin
        if (empty) stat = ST_EMPTY;
        else cmd.pop_front = 1'b1;
      end
      FUNC_POP_REAR: begin
        if (empty) stat = ST_EMPTY;
        else cmd.pop_rear = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (cmd.push_front || cmd.push_rear) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.pop_front || cmd.pop_rear) begin
      count_next = count - CNT_W'(1);
    end
  end

  // Row of cells; cell 0 sees the pushed word on its left, the last cell
  // sees an empty slot on its right.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_data;
    logic                     left_valid;
    logic signed [DATA_W-1:0] right_data;
    logic                     right_valid;
    logic                     right_last;

    if (i == 0) begin : g_head
      assign left_data  = value;
      assign left_valid = 1'b1;
    end else begin : g_body
      assign left_data  = cell_data[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_data  = '0;
      assign right_valid = 1'b0;
      assign right_last  = 1'b0;
    end else begin : g_inner
      assign right_data  = cell_data[i+1];
      assign right_valid = cell_valid[i+1];
      assign right_last  = cell_last[i+1];
    end

    deq_cell u_cell (
      .clk            (clk),
      .rst            (rst),
      .cmd            (cell_cmd),
      .push_word      (value),
      .left_data      (left_data),
      .left_valid     (left_valid),
      .right_data     (right_data),
      .right_valid    (right_valid),
      .right_last     (right_last),
      .data           (cell_data[i]),
      .valid          (cell_valid[i]),
      .last           (cell_last[i]),
      .rear_word      (cell_rear[i]),
      .prev_rear_word (cell_prev_rear[i])
    );
  end

  // At most one cell flags itself last, and at most one next-to-last.
  always_comb begin
    rear_now  = '0;
    rear_prev = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_now  = rear_now | cell_rear[i];
      rear_prev = rear_prev | cell_prev_rear[i];
    end
  end

  // Result words as they stand after the operation.
  always_comb begin
    res_popped = '0;
    res_front  = cell_data[0];
    res_rear   = rear_now;
    priority if (cmd.push_front) begin
      res_front = value;
      if (empty) res_rear = value;
    end else if (cmd.push_rear) begin
      res_rear = value;
      if (empty) res_front = value;
    end else if (cmd.pop_front) begin
      res_popped = cell_data[0];
      res_front  = cell_data[1];
    end else if (cmd.pop_rear) begin
      res_popped = rear_now;
      res_rear   = rear_prev;
    end else begin
      // No move: report the row as it stands.
    end
    if (count_next == '0) begin
      res_front = '0;
      res_rear  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (accept) begin
      popped_value <= res_popped;
      front_value  <= res_front;
      rear_value   <= res_rear;
      occupancy    <= count_next;
      is_empty     <= (count_next == '0);
      status       <= stat;
    end
  end

endmodule

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import deq_pkg::*;

  // Result registered in the cycle after the word is accepted.
  localparam int BLOCK_LATENCY = 1;
  localparam int IDLE_LIMIT    = 2000;
  localparam int RANDOM_OPS    = 1250;
  localparam int DIRECTED_N    = 25;
  localparam int REPORT_MAX    = 10;

  // Spare function codes; the block must treat them as no operation.
  localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped;
    logic signed [DATA_W-1:0] front;
    logic signed [DATA_W-1:0] rear;
    logic [CNT_W-1:0]         occ;
    logic                     is_empty;
    logic [STAT_W-1:0]        status;
  } deq_result_t;

  // One row of the directed table: the word to send and, when typed is set,
  // the result written out by hand instead of taken from the shadow deque.
  typedef struct packed {
    logic [FUNC_W-1:0]        op;
    logic signed [DATA_W-1:0] word;
    logic                     typed;
    deq_result_t              want;
  } stim_row_t;

  localparam deq_result_t EMPTY_REFUSED = '{'0, '0, '0, '0, 1'b1, ST_EMPTY};
  localparam deq_result_t IDLE_EMPTY    = '{'0, '0, '0, '0, 1'b1, ST_OK};
  localparam deq_result_t FROM_SHADOW   = '0;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [FUNC_W-1:0]        func = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] popped_value;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] rear_value;
  logic [CNT_W-1:0]         occupancy;
  logic                     is_empty;
  logic [STAT_W-1:0]        status;

  double_ended_queue_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .popped_value (popped_value),
    .front_value  (front_value),
    .rear_value   (rear_value),
    .occupancy    (occupancy),
    .is_empty     (is_empty),
    .status       (status)
  );

  // Shadow copy of the deque: ring of words, front index and count.
  logic signed [DATA_W-1:0] shadow_words [DEPTH];
  int                       shadow_head = 0;
  int                       shadow_count = 0;

  deq_result_t expected_results [$];
  int          fault_count = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  int          calm_left = 0;
  int          stall_left = 0;

  // Directed opening: refused pops on an empty deque, a no-op and a spare code,
  // the signed extremes in and out of both ends, then a fill to the brim and
  // one push too many. Rows whose result is obvious carry it typed in.
  stim_row_t directed_rows [DIRECTED_N] = '{
    '{FUNC_POP_FRONT,  '0,             1'b1, EMPTY_REFUSED},
    '{FUNC_POP_REAR,   32'sh1234_5678, 1'b1, EMPTY_REFUSED},
    '{FUNC_NONE,       32'shDEAD_BEEF, 1'b1, IDLE_EMPTY},
    '{FUNC_SPARE_HI,   32'shFFFF_FFFF, 1'b1, IDLE_EMPTY},
    '{FUNC_PUSH_FRONT, WORD_MAX,       1'b1,
      '{'0, WORD_MAX, WORD_MAX, CNT_W'(1), 1'b0, ST_OK}},
    '{FUNC_PUSH_REAR,  WORD_MIN,       1'b1,
      '{'0, WORD_MAX, WORD_MIN, CNT_W'(2), 1'b0, ST_OK}},
    '{FUNC_POP_FRONT,  32'sh0F0F_0F0F, 1'b1,
      '{WORD_MAX, WORD_MIN, WORD_MIN, CNT_W'(1), 1'b0, ST_OK}},
    '{FUNC_POP_REAR,   '0,             1'b1,
      '{WORD_MIN, '0, '0, CNT_W'(0), 1'b1, ST_OK}},
    '{FUNC_PUSH_REAR,  '0,             1'b0, FROM_SHADOW},
    '{FUNC_PUSH_FRONT, 32'shFFFF_FFFF, 1'b0, FROM_SHADOW},
    '{FUNC_PUSH_REAR,  32'sh5555_5555, 1'b0, FROM_SHADOW},
    '{FUNC_PUSH_FRONT, 32'shAAAA_AAAA, 1'b0, FROM_SHADOW},
    '{FUNC_PUSH_FRONT, 32'sh0000_0001, 1'b0, FROM_SHADOW},
    '{FUNC_PUSH_REAR,  32'sh8000_0001, 1'b0, FROM_SHADOW},
    '{FUNC_PUSH_FRONT, 32'sh7FFF_FFFE, 1'b0, FROM_SHADOW},
    '{FUNC_PUSH_REAR,  32'sh0001_0000, 1'b0, FROM_SHADOW},
    '{FUNC_PUSH_FRONT, 32'shC3C3_C3C3, 1'b0, FROM_SHADOW},
    '{FUNC_PUSH_REAR,  32'sh3C3C_3C3C, 1'b0, FROM_SHADOW},
    '{FUNC_PUSH_FRONT, 32'sh00FF_00FF, 1'b0, FROM_SHADOW},
    '{FUNC_PUSH_REAR,  32'shFF00_FF00, 1'b0, FROM_SHADOW},
    '{FUNC_PUSH_FRONT, 32'sh1357_9BDF, 1'b0, FROM_SHADOW},
    '{FUNC_PUSH_REAR,  32'sh2468_ACE0, 1'b0, FROM_SHADOW},
    '{FUNC_PUSH_FRONT, WORD_MIN,       1'b0, FROM_SHADOW},
    '{FUNC_PUSH_REAR,  WORD_MAX,       1'b0, FROM_SHADOW},
    '{FUNC_PUSH_FRONT, 32'sh6666_6666, 1'b0, FROM_SHADOW}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one operation to the shadow deque and return the result it owes.
  function automatic deq_result_t deque_step(input logic [FUNC_W-1:0] op,
                                             input logic signed [DATA_W-1:0] word);
    deq_result_t r;
    r = '0;
    r.status = ST_OK;
    case (op)
      FUNC_PUSH_FRONT, FUNC_PUSH_REAR: begin
        if (shadow_count == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (op == FUNC_PUSH_FRONT) begin
            shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
            shadow_words[shadow_head] = word;
          end else begin
            shadow_words[(shadow_head + shadow_count) % DEPTH] = word;
          end
          shadow_count++;
        end
      end
      FUNC_POP_FRONT, FUNC_POP_REAR: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (op == FUNC_POP_FRONT) begin
            r.popped = shadow_words[shadow_head];
            shadow_head = (shadow_head + 1) % DEPTH;
          end else begin
            r.popped = shadow_words[(shadow_head + shadow_count - 1) % DEPTH];
          end
          shadow_count--;
        end
      end
      default: ;
    endcase
    if (shadow_count != 0) begin
      r.front = shadow_words[shadow_head];
      r.rear  = shadow_words[(shadow_head + shadow_count - 1) % DEPTH];
    end
    r.occ      = CNT_W'(shadow_count);
    r.is_empty = (shadow_count == 0);
    return r;
  endfunction

  // Offer one word and hold it until accepted. Bursts of back-to-back words
  // are broken by short gaps with in_valid low; now and then a long burst
  // runs with no gap at all.
  task automatic send_word(input logic [FUNC_W-1:0] op,
                           input logic signed [DATA_W-1:0] word,
                           input logic typed, input deq_result_t want);
    deq_result_t predicted;
    int          gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      if ($urandom_range(0, 9) == 0) begin
        burst_left = $urandom_range(100, 200);
      end else begin
        burst_left = $urandom_range(1, 12);
      end
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    func     <= op;
    value    <= word;
    // Handshake signals are read at the edge, before any register updates.
    do @(posedge clk); while (!in_ready);
    predicted = deque_step(op, word);
    expected_results.push_back(typed ? want : predicted);
  endtask

  // Stimulus: directed table first, then random traffic in fill, drain and
  // mixed phases so the deque keeps hitting both full and empty.
  initial begin
    int                       pushes_and_pops;
    int                       mode_left;
    int                       push_bias;
    logic [FUNC_W-1:0]        op;
    logic signed [DATA_W-1:0] word;
    pushes_and_pops = 0;
    mode_left = 0;
    push_bias = 50;
    rst <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].op, directed_rows[i].word,
                directed_rows[i].typed, directed_rows[i].want);
    end

    while (pushes_and_pops < RANDOM_OPS) begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(24, 64);
        case ($urandom_range(0, 2))
          0:       push_bias = 75;
          1:       push_bias = 25;
          default: push_bias = 50;
        endcase
      end
      case ($urandom_range(0, 15))
        0:       word = WORD_MAX;
        1:       word = WORD_MIN;
        2:       word = '0;
        3:       word = '1;
        default: word = $urandom;
      endcase
      if ($urandom_range(0, 99) < 6) begin
        // Noise: no-op or a spare code; does not count toward the total.
        if ($urandom_range(0, 3) == 0) begin
          op = FUNC_NONE;
        end else begin
          op = FUNC_SPARE_LO + FUNC_W'($urandom_range(0, 2));
        end
      end else begin
        if ($urandom_range(0, 99) < push_bias) begin
          op = $urandom_range(0, 1) ? FUNC_PUSH_FRONT : FUNC_PUSH_REAR;
        end else begin
          op = $urandom_range(0, 1) ? FUNC_POP_FRONT : FUNC_POP_REAR;
        end
        pushes_and_pops++;
        mode_left--;
      end
      send_word(op, word, 1'b0, FROM_SHADOW);
    end

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    // Drain: give any stray result time to show up.
    repeat (BLOCK_LATENCY + 3) @(posedge clk);
    if (fault_count == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Receiver: calm stretches with out_ready held high, short random stalls
  // and occasional longer ones.
  always @(posedge clk) begin
    if (calm_left != 0) begin
      calm_left--;
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      case ($urandom_range(0, 3))
        0:       calm_left = $urandom_range(20, 80);
        1:       stall_left = $urandom_range(1, 15);
        default: stall_left = $urandom_range(0, 1);
      endcase
    end
  end

  // Check every accepted result against the oldest expectation.
  always @(posedge clk) begin
    deq_result_t got;
    deq_result_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{popped_value, front_value, rear_value, occupancy, is_empty, status};
      if (expected_results.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_MAX) begin
          $display("%0t: result with nothing expected: popped=%h front=%h rear=%h",
                   $realtime, got.popped, got.front, got.rear);
        end
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          fault_count++;
          if (fault_count <= REPORT_MAX) begin
            $display("%0t: mismatch exp popped=%h front=%h rear=%h occ=%0d empty=%b st=%0d",
                     $realtime, want.popped, want.front, want.rear, want.occ,
                     want.is_empty, want.status);
            $display("%0t:          got popped=%h front=%h rear=%h occ=%0d empty=%b st=%0d",
                     $realtime, got.popped, got.front, got.rear, got.occ,
                     got.is_empty, got.status);
          end
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves a word for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $realtime, IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule
